[rtl/core/ats_pkg.sv]
// Shared types, constants and character classes for the assembler token scanner.
// Depends on nothing; imported by every module of the scanner.
package ats_pkg;

    // Field widths
    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int ID_BITS     = 16;
    localparam int KIND_BITS   = 5;
    localparam int CH_BITS     = 8;
    localparam int PREFIX_BITS = 3 * CH_BITS;
    localparam int TOKEN_BITS  = KIND_BITS + OFFSET_BITS + LENGTH_BITS + ID_BITS;
    localparam int M_DATA_BITS = ((TOKEN_BITS + 7) / 8) * 8;
    localparam int MAX_TOKENS  = 3;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // Characters with a role of their own
    localparam logic [CH_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_BITS-1:0] CH_NL    = 8'h0a;
    localparam logic [CH_BITS-1:0] CH_SLASH = "/";
    localparam logic [CH_BITS-1:0] CH_ZERO  = "0";
    localparam logic [CH_BITS-1:0] CH_X     = "x";
    localparam logic [CH_BITS-1:0] CH_UNDER = "_";

    typedef enum logic [KIND_BITS-1:0] {
        KIND_END      = 5'd0,
        KIND_COMMA    = 5'd1,
        KIND_COLON    = 5'd2,
        KIND_SEMI     = 5'd3,
        KIND_LPAREN   = 5'd4,
        KIND_RPAREN   = 5'd5,
        KIND_LBRACE   = 5'd6,
        KIND_RBRACE   = 5'd7,
        KIND_LBRACKET = 5'd8,
        KIND_RBRACKET = 5'd9,
        KIND_AT       = 5'd10,
        KIND_PLUS     = 5'd11,
        KIND_MINUS    = 5'd12,
        KIND_NUMBER   = 5'd13,
        KIND_IDENT    = 5'd14,
        KIND_FN       = 5'd15,
        KIND_SIZE     = 5'd16,
        KIND_REG      = 5'd17,
        KIND_ERROR    = 5'd18
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_ZERO    = 3'd3,
        MODE_HEX     = 3'd4,
        MODE_DEC     = 3'd5,
        MODE_IDENT   = 3'd6
    } scan_mode_t;

    // Kind sits in the lowest bits so the packed token maps straight onto tdata
    typedef struct packed {
        logic [ID_BITS-1:0]     src;
        logic [LENGTH_BITS-1:0] len;
        logic [OFFSET_BITS-1:0] start;
        kind_t                  kind;
    } token_t;

    typedef struct packed {
        scan_mode_t             mode;
        logic [OFFSET_BITS-1:0] pos;
        logic [OFFSET_BITS-1:0] tstart;
        logic [LENGTH_BITS-1:0] tlen;
        logic [PREFIX_BITS-1:0] prefix;
    } scan_state_t;

    function automatic logic is_space(input logic [CH_BITS-1:0] c);
        return c == 8'd10 || c == 8'd9 || c == 8'd13 || c == 8'd12 ||
               c == 8'd11 || c == 8'd7 || c == 8'd8 || c == 8'd32;
    endfunction

    function automatic logic is_digit(input logic [CH_BITS-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [CH_BITS-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_hex(input logic [CH_BITS-1:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_ident(input logic [CH_BITS-1:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    // Punctuator kind, or KIND_END where the byte is none
    function automatic kind_t punct_kind(input logic [CH_BITS-1:0] c);
        kind_t k;
        unique case (c)
            ",":     k = KIND_COMMA;
            ":":     k = KIND_COLON;
            ";":     k = KIND_SEMI;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "[":     k = KIND_LBRACKET;
            "]":     k = KIND_RBRACKET;
            "@":     k = KIND_AT;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            default: k = KIND_END;
        endcase
        return k;
    endfunction

    // Keyword lookup on the packed first three bytes of an identifier
    function automatic kind_t ident_kind(input logic [LENGTH_BITS-1:0] len,
                                         input logic [PREFIX_BITS-1:0] prefix);
        kind_t k;
        unique case (prefix)
            {8'h00, "fn"}:                     k = KIND_FN;
            {8'h00, "b8"}, "b16", "b32", "b64": k = KIND_SIZE;
            "rax", "rcx", "rdx", "rbx", "rsp", "rbp", "rsi", "rdi", "rip",
            {8'h00, "r8"}, {8'h00, "r9"},
            "r10", "r11", "r12", "r13", "r14", "r15": k = KIND_REG;
            default:                           k = KIND_IDENT;
        endcase
        if (len > LENGTH_BITS'(3)) begin
            k = KIND_IDENT;
        end
        return k;
    endfunction

endpackage

[rtl/core/assembler_token_scanner.sv]
// Latency: tokens of an accepted item are offered on m_ the cycle after acceptance.
// Throughput: one item per cycle while each item yields at most one token and m_tready
// is high; an item that yields more tokens holds s_tready low while the three-entry token
// buffer drains, one token per cycle while m_tready is high, through the single m_ port.
// Reset: synchronous, active low; clears scan state, byte offset, file id and the buffer count.
// Top level of the scanner: state, file id and token buffer; uses ats_pkg and ats_step.
module assembler_token_scanner (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: file id
    input  logic                             cfg_wr_en,
    input  logic [ats_pkg::ID_BITS-1:0]      cfg_wr_data,
    // Source bytes
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ats_pkg::CH_BITS-1:0]      s_tdata,   // [7:0] ch
    input  logic                             s_tlast,   // end_of_input
    // Tokens
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ats_pkg::M_DATA_BITS-1:0]  m_tdata,   // kind, start_offset, length,
                                                        // source_id, zero pad
    output logic                             m_tlast    // last_of_run
);
    import ats_pkg::*;

    scan_state_t                 state_reg, state_next;
    logic [ID_BITS-1:0]          file_id_reg;
    token_t [MAX_TOKENS-1:0]     slot_reg, slot_next;
    logic [1:0]                  count_reg, count_next;
    token_t [MAX_TOKENS-1:0]     step_tokens;
    logic [1:0]                  step_count;
    scan_state_t                 step_state;
    logic                        accept;
    logic                        pop;

    ats_step u_step (
        .state_cur   (state_reg),
        .ch          (s_tdata),
        .eoi         (s_tlast),
        .file_id     (file_id_reg),
        .state_new   (step_state),
        .tokens      (step_tokens),
        .token_count (step_count)
    );

    // Handshakes: take an item once the buffer empties in this cycle
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tlast  = (count_reg == 2'd1);
    assign m_tdata  = M_DATA_BITS'(slot_reg[0]);
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_tready);
    assign accept   = s_tvalid && s_tready;

    // Load a whole run on accept, else advance the buffer on a pop
    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        if (accept) begin
            state_next = step_state;
            slot_next  = step_tokens;
            count_next = step_count;
        end else if (pop) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            count_next   = count_reg - 2'd1;
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '{mode: MODE_IDLE, default: '0};
            count_reg   <= 2'd0;
            file_id_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                file_id_reg <= cfg_wr_data;
            end
        end
    end

    // Token payload
    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

endmodule

[rtl/core/ats_step.sv]
// Next-state and token logic of the scanner for one source byte.
// Depends on ats_pkg; instantiated by assembler_token_scanner.
module ats_step (
    input  ats_pkg::scan_state_t                   state_cur,
    input  logic [ats_pkg::CH_BITS-1:0]            ch,
    input  logic                                   eoi,
    input  logic [ats_pkg::ID_BITS-1:0]            file_id,
    output ats_pkg::scan_state_t                   state_new,
    output ats_pkg::token_t [ats_pkg::MAX_TOKENS-1:0] tokens,
    output logic [1:0]                             token_count
);
    import ats_pkg::*;

    function automatic token_t make_tok(input kind_t k,
                                        input logic [OFFSET_BITS-1:0] s,
                                        input logic [LENGTH_BITS-1:0] l,
                                        input logic [ID_BITS-1:0] id);
        token_t t;
        t.kind  = k;
        t.start = s;
        t.len   = l;
        t.src   = id;
        return t;
    endfunction

    localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;

    // Scan the byte, close a pending token, then flush and end on end of input or a NUL byte
    always_comb begin
        scan_state_t            mid;
        token_t                 cand [4];
        logic [3:0]             cand_v;
        logic [2:0]             cnt;
        logic                   run_idle;
        logic                   closing;
        logic [OFFSET_BITS-1:0] pos_inc;
        logic [LENGTH_BITS-1:0] len_grow;
        kind_t                  pk;

        mid      = state_cur;
        cand_v   = '0;
        run_idle = 1'b0;
        pos_inc  = state_cur.pos + OFFSET_BITS'(1);
        len_grow = (state_cur.tlen == LEN_MAX) ? state_cur.tlen
                                                : state_cur.tlen + LEN_ONE;
        pk       = punct_kind(ch);
        for (int i = 0; i < 4; i++) begin
            cand[i] = make_tok(KIND_END, '0, LEN_ZERO, file_id);
        end

        if (ch != CH_NUL) begin
            // Continue or close the pending token
            unique case (state_cur.mode)
                MODE_SLASH: begin
                    if (ch == CH_SLASH) begin
                        mid.mode = MODE_COMMENT;
                    end else begin
                        cand_v[0] = 1'b1;
                        cand[0]   = make_tok(KIND_ERROR, state_cur.tstart, LEN_ONE, file_id);
                        run_idle  = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (ch == CH_NL) begin
                        mid.mode = MODE_IDLE;
                    end
                end
                MODE_ZERO: begin
                    if (ch == CH_X) begin
                        mid.mode = MODE_HEX;
                        mid.tlen = LENGTH_BITS'(2);
                    end else begin
                        cand_v[0] = 1'b1;
                        cand[0]   = make_tok(is_digit(ch) ? KIND_ERROR : KIND_NUMBER,
                                             state_cur.tstart, LEN_ONE, file_id);
                        run_idle  = 1'b1;
                    end
                end
                MODE_HEX, MODE_DEC: begin
                    if ((state_cur.mode == MODE_HEX) ? is_hex(ch) : is_digit(ch)) begin
                        mid.tlen = len_grow;
                    end else begin
                        cand_v[0] = 1'b1;
                        cand[0]   = make_tok(KIND_NUMBER, state_cur.tstart,
                                             state_cur.tlen, file_id);
                        run_idle  = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_ident(ch)) begin
                        if (state_cur.tlen < LENGTH_BITS'(3)) begin
                            mid.prefix = {state_cur.prefix[PREFIX_BITS-CH_BITS-1:0], ch};
                        end
                        mid.tlen = len_grow;
                    end else begin
                        cand_v[0] = 1'b1;
                        cand[0]   = make_tok(ident_kind(state_cur.tlen, state_cur.prefix),
                                             state_cur.tstart, state_cur.tlen, file_id);
                        run_idle  = 1'b1;
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase

            // Start a new token from idle
            if (run_idle) begin
                mid.mode = MODE_IDLE;
                if (!is_space(ch)) begin
                    priority if (pk != KIND_END) begin
                        cand_v[1] = 1'b1;
                        cand[1]   = make_tok(pk, state_cur.pos, LEN_ONE, file_id);
                    end else if (ch == CH_SLASH || is_digit(ch) || is_alpha(ch) ||
                                 ch == CH_UNDER) begin
                        mid.tstart = state_cur.pos;
                        mid.tlen   = LEN_ONE;
                        priority if (ch == CH_SLASH) begin
                            mid.mode = MODE_SLASH;
                        end else if (ch == CH_ZERO) begin
                            mid.mode = MODE_ZERO;
                        end else if (is_digit(ch)) begin
                            mid.mode = MODE_DEC;
                        end else begin
                            mid.mode   = MODE_IDENT;
                            mid.prefix = PREFIX_BITS'(ch);
                        end
                    end else begin
                        cand_v[1] = 1'b1;
                        cand[1]   = make_tok(KIND_ERROR, state_cur.pos, LEN_ONE, file_id);
                    end
                end
            end
            mid.pos = pos_inc;
        end

        // Flush the pending token and emit the end token
        closing = (ch == CH_NUL) || eoi;
        if (closing) begin
            unique case (mid.mode)
                MODE_SLASH: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_tok(KIND_ERROR, mid.tstart, LEN_ONE, file_id);
                end
                MODE_ZERO: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_tok(KIND_NUMBER, mid.tstart, LEN_ONE, file_id);
                end
                MODE_HEX, MODE_DEC: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_tok(KIND_NUMBER, mid.tstart, mid.tlen, file_id);
                end
                MODE_IDENT: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_tok(ident_kind(mid.tlen, mid.prefix),
                                         mid.tstart, mid.tlen, file_id);
                end
                default: begin
                    cand_v[2] = 1'b0;
                end
            endcase
            cand_v[3] = 1'b1;
            cand[3]   = make_tok(KIND_END, (ch == CH_NUL) ? state_cur.pos : pos_inc,
                                 LEN_ZERO, file_id);
            mid = '{mode: MODE_IDLE, default: '0};
        end
        state_new = mid;

        // Pack the valid tokens in order
        tokens = '0;
        cnt    = '0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && cnt < 3'(MAX_TOKENS)) begin
                tokens[cnt[1:0]] = cand[i];
                cnt              = cnt + 3'd1;
            end
        end
        token_count = cnt[1:0];
    end

endmodule

[rtl/core/ats_checker.sv]
// Port-level checks of the assembler token scanner and the bind that attaches them.
// Depends on ats_pkg; bound to assembler_token_scanner.
module ats_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_wr_en,
    input logic [ats_pkg::ID_BITS-1:0]      cfg_wr_data,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [ats_pkg::CH_BITS-1:0]      s_tdata,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ats_pkg::M_DATA_BITS-1:0]  m_tdata,
    input logic                             m_tlast
);
    import ats_pkg::*;

    logic [KIND_BITS-1:0]   tok_kind;
    logic [LENGTH_BITS-1:0] tok_len;

    assign tok_kind = m_tdata[KIND_BITS-1:0];
    assign tok_len  = m_tdata[KIND_BITS+OFFSET_BITS +: LENGTH_BITS];

    // Hold a stalled token
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled token changed");

    // End token closes its run and is empty
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && tok_kind == KIND_END |-> m_tlast && tok_len == '0)
        else $error("end token not last or not empty");

    // Only the end token has zero length
    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && tok_len == '0 |-> tok_kind == KIND_END)
        else $error("empty token that is not end");

    // No new item while a run still has more than one token to deliver
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("item taken while run pending");

endmodule

bind assembler_token_scanner ats_checker u_ats_checker (.*);
